// File: rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync frame receiver package
// Types and constants shared by the front end, item queue and back end.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'h13;
   // The header bytes are always part of the sum, so a frame starts from their total.
   localparam logic [7:0] SUM_SEED    = 8'h68;
   localparam logic [5:0] FIRST_BODY_POS = 6'd2;

   localparam int PAYLOAD_COUNT    = 12;
   localparam int ITEM_QUEUE_DEPTH = 4;
   localparam int RESULT_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_BODY,
      KIND_CHECK
   } item_kind_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] slot;
   } slot_hit_type;

   typedef struct packed {
      item_kind_type kind;
      slot_hit_type  capture;
      logic [7:0]    data;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef logic [PAYLOAD_COUNT-1:0][7:0] payload_type;

   // Maps a frame offset to its payload slot.
   function automatic slot_hit_type slot_lookup(input logic [5:0] pos);
      slot_hit_type r;
      r.hit  = 1'b1;
      r.slot = 4'd0;
      case (pos)
         6'd2:    r.slot = 4'd0;
         6'd6:    r.slot = 4'd1;
         6'd7:    r.slot = 4'd2;
         6'd9:    r.slot = 4'd3;
         6'd10:   r.slot = 4'd4;
         6'd14:   r.slot = 4'd5;
         6'd15:   r.slot = 4'd6;
         6'd16:   r.slot = 4'd7;
         6'd17:   r.slot = 4'd8;
         6'd18:   r.slot = 4'd9;
         6'd19:   r.slot = 4'd10;
         6'd20:   r.slot = 4'd11;
         default: r.hit  = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/sfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync frame receiver front end
// Hunts for the header, tracks the offset within a frame and tags each
// in-frame byte as frame start, body byte or checksum byte.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; #(
   parameter int FRAME_LENGTH = 47
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output logic       item_push,
   output item_type   item
);

   localparam logic [5:0] CHECK_POS = 6'(FRAME_LENGTH - 1);

   logic       half_seen_ff, half_seen_in;
   logic       in_frame_ff, in_frame_in;
   logic [5:0] pos_ff, pos_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_seen_ff <= 1'b0;
         in_frame_ff  <= 1'b0;
         pos_ff       <= 6'd0;
      end else begin
         half_seen_ff <= half_seen_in;
         in_frame_ff  <= in_frame_in;
         pos_ff       <= pos_in;
      end
   end

   always_comb begin
      half_seen_in = half_seen_ff;
      in_frame_in  = in_frame_ff;
      pos_in       = pos_ff;
      item_push    = 1'b0;
      item.kind    = KIND_BODY;
      item.capture = slot_lookup(pos_ff);
      item.data    = rx_byte;
      if (accept) begin
         if (!in_frame_ff) begin
            if (half_seen_ff && rx_byte == SYNC_SECOND) begin
               in_frame_in  = 1'b1;
               half_seen_in = 1'b0;
               pos_in       = FIRST_BODY_POS;
               item_push    = 1'b1;
               item.kind    = KIND_START;
            end else begin
               half_seen_in = (rx_byte == SYNC_FIRST);
            end
         end else if (pos_ff >= CHECK_POS) begin
            in_frame_in  = 1'b0;
            half_seen_in = 1'b0;
            pos_in       = 6'd0;
            item_push    = 1'b1;
            item.kind    = KIND_CHECK;
         end else begin
            pos_in    = pos_ff + 6'd1;
            item_push = 1'b1;
         end
      end
   end

`ifndef SYNTH
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (pos_ff >= FIRST_BODY_POS && pos_ff <= CHECK_POS))
      else $error("frame offset out of range");
   a_pos_idle: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (pos_ff == 6'd0))
      else $error("offset not cleared while hunting");
`endif

endmodule

// File: rtl/sfr_item_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync frame receiver item queue
// Short queue of tagged bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module sfr_item_queue import sfr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(ITEM_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ITEM_QUEUE_DEPTH + 1);

   item_type               entries [ITEM_QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(ITEM_QUEUE_DEPTH));
   assign head         = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("item queue overflow");
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !status.empty)
      else $error("item queue empty after push");
`endif

endmodule

// File: rtl/sfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync frame receiver back end
// Keeps the running sum and payload bytes, checks the checksum byte and
// queues the payload of each good frame as a result.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  item_type         head,
   input  queue_status_type item_status,
   output logic             item_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output payload_type      rsp_payload
);

   localparam int PTR_W = $clog2(RESULT_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(RESULT_QUEUE_DEPTH + 1);

   logic [7:0]        sum_ff, sum_in;
   payload_type       payload_ff;
   payload_type       results [RESULT_QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              res_full, res_push, res_pop;

   assign res_full  = (count_ff == CNT_W'(RESULT_QUEUE_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign res_pop   = rsp_pop && !rsp_empty;

   // A checksum item waits until the result queue has room.
   assign item_pop = !item_status.empty && (head.kind != KIND_CHECK || !res_full);
   assign res_push = item_pop && head.kind == KIND_CHECK && head.data == sum_ff;

   always_comb begin
      sum_in = sum_ff;
      if (item_pop) begin
         case (head.kind)
            KIND_START: sum_in = SUM_SEED;
            KIND_BODY:  sum_in = sum_ff + head.data;
            KIND_CHECK: sum_in = 8'd0;
            default:    sum_in = sum_ff;
         endcase
      end
      count_in = count_ff;
      if (res_push && !res_pop) begin
         count_in = count_ff + 1'b1;
      end else if (res_pop && !res_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= 8'd0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         if (res_push) begin
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (res_pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && head.kind == KIND_BODY && head.capture.hit) begin
         payload_ff[head.capture.slot] <= head.data;
      end
      if (res_push) begin
         results[wr_ptr_ff] <= payload_ff;
      end
   end

   assign rsp_payload = results[rd_ptr_ff];

`ifndef SYNTH
   a_no_result_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> (!res_full || res_pop))
      else $error("result queue overflow");
   a_result_visible: assert property (@(posedge clock) disable iff (reset)
      (res_push && !res_pop) |=> !rsp_empty)
      else $error("pushed result not visible");
`endif

endmodule

// File: rtl/sync_checksum_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync checksum frame receiver
// Finds 0x55 0x13 framed packets in a byte stream, checks the additive
// checksum and delivers twelve payload bytes for each good frame.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, every cycle, as long as results are drained.
// A good frame's payload reaches the rsp_ ports once its checksum item has
// passed the item queue. Results wait in a two-entry result queue; when it
// is full, checksum items back up in the four-entry item queue between the
// front and back ends, and req_full rises once that queue fills.
// ----------------------------------------------------------------------------
module sync_checksum_frame_receiver import sfr_pkg::*; #(
   parameter int FRAME_LENGTH = 47
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_payload_at_2,
   output logic [7:0] rsp_payload_at_6,
   output logic [7:0] rsp_payload_at_7,
   output logic [7:0] rsp_payload_at_9,
   output logic [7:0] rsp_payload_at_10,
   output logic [7:0] rsp_payload_at_14,
   output logic [7:0] rsp_payload_at_15,
   output logic [7:0] rsp_payload_at_16,
   output logic [7:0] rsp_payload_at_17,
   output logic [7:0] rsp_payload_at_18,
   output logic [7:0] rsp_payload_at_19,
   output logic [7:0] rsp_payload_at_20
);

   logic             accept;
   logic             item_push;
   logic             item_pop;
   item_type         push_item;
   item_type         head;
   queue_status_type item_status;
   payload_type      payload;

   assign req_full = item_status.full;
   assign accept   = req_push && !item_status.full;

   sfr_front #(
      .FRAME_LENGTH(FRAME_LENGTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .item_push (item_push),
      .item      (push_item)
   );

   sfr_item_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_item (push_item),
      .pop       (item_pop),
      .head      (head),
      .status    (item_status)
   );

   sfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .item_status (item_status),
      .item_pop    (item_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_payload (payload)
   );

   assign rsp_payload_at_2  = payload[0];
   assign rsp_payload_at_6  = payload[1];
   assign rsp_payload_at_7  = payload[2];
   assign rsp_payload_at_9  = payload[3];
   assign rsp_payload_at_10 = payload[4];
   assign rsp_payload_at_14 = payload[5];
   assign rsp_payload_at_15 = payload[6];
   assign rsp_payload_at_16 = payload[7];
   assign rsp_payload_at_17 = payload[8];
   assign rsp_payload_at_18 = payload[9];
   assign rsp_payload_at_19 = payload[10];
   assign rsp_payload_at_20 = payload[11];

endmodule
